[rtl/lres_pkg.sv]
// Shared types and constants for the LED ring expression sequencer.
// No dependencies; the rtl files that use it refer to it by scoped names.
package lres_pkg;

  localparam int NUM_PIXELS_DEFAULT = 12;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALERT_RED  = 1'b1;

  localparam logic [7:0]  BRIGHTNESS_RESET = 8'd128;
  localparam logic [7:0]  LEVEL_MAX        = 8'd255;
  localparam logic [31:0] GATE_MS          = 32'd30;
  localparam logic [31:0] HALF_PERIOD_MS   = 32'd1000;
  localparam logic [1:0]  ALERT_ON_MAX     = 2'd3;

  // Pattern pixel positions
  localparam int PILOT_PIXEL   = 6;
  localparam int ALERT_PIXEL   = 0;
  localparam int NEUTRAL_FIRST = 5;
  localparam int NEUTRAL_LAST  = 7;
  localparam int SMILE_FIRST   = 4;
  localparam int SMILE_LAST    = 8;
  localparam int SAD_COUNT     = 5;
  localparam int SAD_PIXELS [SAD_COUNT] = '{10, 11, 0, 1, 2};

  typedef enum logic [2:0] {
    EXPR_NONE    = 3'd0,
    EXPR_BLINK   = 3'd1,
    EXPR_WHITE   = 3'd2,
    EXPR_ALERT   = 3'd3,
    EXPR_NEUTRAL = 3'd4,
    EXPR_SMILE   = 3'd5,
    EXPR_SAD     = 3'd6,
    EXPR_UNKNOWN = 3'd7
  } expr_t;

  // Whole-frame paint operation applied during the readout sweep
  typedef enum logic [2:0] {
    PAINT_PILOT,      // pilot pixel takes paint color, rest kept
    PAINT_FILL,       // whole ring takes paint color
    PAINT_NEUTRAL,
    PAINT_SMILE,
    PAINT_SAD,
    PAINT_ALERT_PIX0, // ring dark, alert pixel takes paint color
    PAINT_PIX0_OFF    // alert pixel dark, rest kept
  } paint_op_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

endpackage

[rtl/lres_if.sv]
// Handshake channels of the LED ring expression sequencer: command beats in,
// pixel beats out. No dependencies.
interface lres_cmd_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [2:0]  expression;
  logic [31:0] timeout_ms;
  logic        urgency_active;

  modport source (output valid, mode, expression, timeout_ms, urgency_active,
                  input ready);
  modport sink   (input valid, mode, expression, timeout_ms, urgency_active,
                  output ready);
endinterface

interface lres_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       full_intensity;
  logic [2:0] expression_code;
  logic       effect_running;
  logic       frame_last;

  modport source (output valid, pixel_index, red, green, blue, full_intensity,
                  expression_code, effect_running, frame_last, input ready);
  modport sink   (input valid, pixel_index, red, green, blue, full_intensity,
                  expression_code, effect_running, frame_last, output ready);
endinterface

[rtl/lres_alu.sv]
// Shared 32-bit add/subtract unit with registered result and borrow/carry.
// Depends on nothing.
module lres_alu (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [32:0] res
);

  always_ff @(posedge clk) begin
    if (sub) begin
      res <= {1'b0, a} - {1'b0, b};
    end else begin
      res <= {1'b0, a} + {1'b0, b};
    end
  end

endmodule

[rtl/lres_fb.sv]
// Frame buffer: one write and one registered read per cycle, per-entry
// valid bits so unwritten pixels read dark after reset. Uses lres_pkg.
module lres_fb #(
  parameter  int NUM_PIXELS = lres_pkg::NUM_PIXELS_DEFAULT,
  localparam int AW         = $clog2(NUM_PIXELS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  lres_pkg::rgb_t     wdata,
  input  logic [AW-1:0]      raddr,
  output lres_pkg::rgb_t     rdata
);

  lres_pkg::rgb_t          mem [NUM_PIXELS];
  logic [NUM_PIXELS-1:0]   valid;
  lres_pkg::rgb_t          rd_data;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data  <= mem[raddr];
    rd_valid <= valid[raddr];
  end

  assign rdata = rd_valid ? rd_data : '0;

endmodule

[rtl/lres_paint.sv]
// Per-pixel paint logic: new color of one pixel from the frame paint
// operation, the pixel index and the stored color. Uses lres_pkg.
module lres_paint #(
  parameter  int NUM_PIXELS = lres_pkg::NUM_PIXELS_DEFAULT,
  localparam int AW         = $clog2(NUM_PIXELS)
) (
  input  lres_pkg::paint_op_t op,
  input  logic [AW-1:0]       idx,
  input  lres_pkg::rgb_t      old,
  input  lres_pkg::rgb_t      paint,
  input  logic [7:0]          brightness,
  output lres_pkg::rgb_t      color
);

  logic [7:0]     med;
  lres_pkg::rgb_t green_med;
  lres_pkg::rgb_t sad_color;
  logic           sad_hit;
  int             pix;

  assign med       = brightness >> 1;
  assign green_med = '{r: 8'd0, g: med, b: 8'd0};
  assign sad_color = '{r: med, g: med >> 1, b: 8'd0};
  assign pix       = int'(idx);

  always_comb begin
    sad_hit = 1'b0;
    for (int j = 0; j < lres_pkg::SAD_COUNT; j++) begin
      if (pix == lres_pkg::SAD_PIXELS[j]) sad_hit = 1'b1;
    end
  end

  always_comb begin
    unique case (op)
      lres_pkg::PAINT_PILOT:
        color = (pix == lres_pkg::PILOT_PIXEL) ? paint : old;
      lres_pkg::PAINT_FILL:
        color = paint;
      lres_pkg::PAINT_NEUTRAL:
        color = (pix >= lres_pkg::NEUTRAL_FIRST && pix <= lres_pkg::NEUTRAL_LAST)
                ? green_med : '0;
      lres_pkg::PAINT_SMILE:
        color = (pix >= lres_pkg::SMILE_FIRST && pix <= lres_pkg::SMILE_LAST)
                ? green_med : '0;
      lres_pkg::PAINT_SAD:
        color = sad_hit ? sad_color : '0;
      lres_pkg::PAINT_ALERT_PIX0:
        color = (pix == lres_pkg::ALERT_PIXEL) ? paint : '0;
      lres_pkg::PAINT_PIX0_OFF:
        color = (pix == lres_pkg::ALERT_PIXEL) ? '0 : old;
      default:
        color = old;
    endcase
  end

endmodule

[rtl/led_ring_expression_sequencer.sv]
// LED ring expression sequencer, top level.
// Depends on lres_pkg, lres_if, lres_alu, lres_fb and lres_paint.
//
// Usage: the cmd channel carries one beat per 1 ms tick (mode 0) or per
// expression command (mode 1, with timeout_ms, 0 = persistent). Each beat
// that redraws the ring produces one frame on the pix channel: NUM_PIXELS
// beats, pixel 0 first, frame_last on the final pixel. Beats that draw
// nothing (gated ticks, alert command) produce no output.
// Timing: cmd.ready is high only while idle. A tick walks up to four steps
// through the single shared 32-bit adder (clock increment, 30 ms gate,
// timeout compare, blink period). A command passes S_CMD, then its frame if
// it draws one. A frame opens with a first read (S_PIX_RD). The frame buffer
// has one read and one write port, so each pixel takes a paint/write step
// (S_PIX_WR) and an output step (S_PIX_WAIT), with the next read overlapped
// with the output beat.
// Stall: a pixel beat holds in the output register until pix.ready; the
// sweep waits and no new command beat is taken.
// Reset (synchronous, rst high): timers, effect state and registers return
// to defaults; the frame buffer reads dark through per-pixel valid bits,
// so there is no clearing pass. Configuration writes land at once.
module led_ring_expression_sequencer #(
  parameter int NUM_PIXELS = lres_pkg::NUM_PIXELS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lres_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lres_pkg::CFG_DATA_W-1:0]   cfg_data,
  lres_cmd_if.sink                          cmd,
  lres_pix_if.source                        pix
);

  localparam int AW = $clog2(NUM_PIXELS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PIXELS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,      // adder holds now + timeout
    S_T_INC,    // adder holds now + 1
    S_T_GATE,   // adder holds now - last_process
    S_T_TMO,    // adder holds now - end_time
    S_T_BLK,    // adder holds now - last_blink
    S_PIX_RD,   // first frame buffer read in flight
    S_PIX_WR,   // paint, write back, load output beat
    S_PIX_WAIT  // output beat waiting; next read overlapped
  } state_t;

  state_t state;

  // configuration
  logic [7:0] brightness;
  logic [7:0] alert_red_level;

  // effect state
  logic [31:0]           now_ms;
  logic [31:0]           last_process_ms;
  logic [31:0]           last_blink_ms;
  logic [31:0]           end_time_ms;
  logic                  running;
  lres_pkg::expr_t       cur_expr;
  logic                  blink_on;
  logic [1:0]            alert_on_count;
  logic                  alert_second_stage;
  logic                  intensity_forced;

  // latched command beat
  lres_pkg::expr_t       item_expr;
  logic                  item_tmo_zero;
  logic                  item_urgency;

  // frame paint
  lres_pkg::paint_op_t   paint_op;
  lres_pkg::rgb_t        paint_rgb;
  logic [AW-1:0]         idx;

  // output register
  logic                  out_valid;
  logic [3:0]            out_index;
  lres_pkg::rgb_t        out_rgb;
  logic                  out_forced;
  lres_pkg::expr_t       out_expr;
  logic                  out_running;
  logic                  out_last;

  // datapath
  logic [31:0]           alu_a;
  logic [31:0]           alu_b;
  logic                  alu_sub;
  logic [32:0]           alu_res;
  logic [31:0]           alu_diff;
  logic                  alu_borrow;
  logic [AW-1:0]         fb_raddr;
  lres_pkg::rgb_t        fb_rdata;
  lres_pkg::rgb_t        painted;
  logic                  pix_last;
  logic [7:0]            half_level;
  logic [7:0]            alert_red;
  logic                  blink_next;
  logic [1:0]            alert_cnt_next;
  logic                  cmd_fire;

  assign cmd_fire   = cmd.valid && cmd.ready;
  assign cmd.ready  = (state == S_IDLE);
  assign alu_diff   = alu_res[31:0];
  assign alu_borrow = alu_res[32];
  assign pix_last   = (idx == LAST_IDX);
  assign half_level = brightness >> 1;
  assign alert_red  = (alert_red_level == 8'd0) ? lres_pkg::LEVEL_MAX : alert_red_level;
  assign blink_next = ~blink_on;
  assign alert_cnt_next = (blink_next && alert_on_count != lres_pkg::ALERT_ON_MAX)
                          ? alert_on_count + 2'd1 : alert_on_count;

  // Operand select for the shared adder; each step consumes the prior result.
  always_comb begin
    unique case (state)
      S_T_INC: begin
        alu_a   = alu_diff;
        alu_b   = last_process_ms;
        alu_sub = 1'b1;
      end
      S_T_GATE: begin
        alu_a   = now_ms;
        alu_b   = end_time_ms;
        alu_sub = 1'b1;
      end
      S_T_TMO: begin
        alu_a   = now_ms;
        alu_b   = last_blink_ms;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = now_ms;
        alu_b   = cmd.mode ? cmd.timeout_ms : 32'd1;
        alu_sub = 1'b0;
      end
    endcase
  end

  // Read one ahead while the current beat waits
  assign fb_raddr = (state == S_PIX_WAIT && !pix_last) ? idx + AW'(1) : idx;

  lres_alu u_alu (
    .clk (clk),
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  lres_fb #(.NUM_PIXELS(NUM_PIXELS)) u_fb (
    .clk   (clk),
    .rst   (rst),
    .we    (state == S_PIX_WR),
    .waddr (idx),
    .wdata (painted),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  lres_paint #(.NUM_PIXELS(NUM_PIXELS)) u_paint (
    .op         (paint_op),
    .idx        (idx),
    .old        (fb_rdata),
    .paint      (paint_rgb),
    .brightness (brightness),
    .color      (painted)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= lres_pkg::BRIGHTNESS_RESET;
      alert_red_level <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lres_pkg::CFG_BRIGHTNESS: brightness      <= cfg_data;
        lres_pkg::CFG_ALERT_RED:  alert_red_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      now_ms             <= '0;
      last_process_ms    <= '0;
      last_blink_ms      <= '0;
      end_time_ms        <= '0;
      running            <= 1'b0;
      cur_expr           <= lres_pkg::EXPR_NONE;
      blink_on           <= 1'b0;
      alert_on_count     <= '0;
      alert_second_stage <= 1'b0;
      intensity_forced   <= 1'b0;
      out_valid          <= 1'b0;
      idx                <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            // unknown and zero codes both show as neutral, stored as unknown
            item_expr     <= (lres_pkg::expr_t'(cmd.expression) == lres_pkg::EXPR_NONE)
                             ? lres_pkg::EXPR_UNKNOWN : lres_pkg::expr_t'(cmd.expression);
            item_tmo_zero <= (cmd.timeout_ms == 32'd0);
            item_urgency  <= cmd.urgency_active;
            state         <= cmd.mode ? S_CMD : S_T_INC;
          end
        end

        S_CMD: begin
          cur_expr           <= item_expr;
          running            <= 1'b1;
          last_blink_ms      <= now_ms;
          blink_on           <= 1'b0;
          alert_on_count     <= '0;
          alert_second_stage <= 1'b0;
          end_time_ms        <= item_tmo_zero ? 32'd0 : alu_diff;
          idx                <= '0;
          state              <= S_PIX_RD;
          unique case (item_expr)
            lres_pkg::EXPR_BLINK: begin
              paint_op  <= lres_pkg::PAINT_PILOT;
              paint_rgb <= '0;
            end
            lres_pkg::EXPR_WHITE: begin
              intensity_forced <= 1'b1;
              paint_op  <= lres_pkg::PAINT_FILL;
              paint_rgb <= '{r: lres_pkg::LEVEL_MAX, g: lres_pkg::LEVEL_MAX,
                             b: lres_pkg::LEVEL_MAX};
            end
            lres_pkg::EXPR_ALERT: begin
              state <= S_IDLE;  // alert start draws nothing
            end
            lres_pkg::EXPR_SMILE: paint_op <= lres_pkg::PAINT_SMILE;
            lres_pkg::EXPR_SAD:   paint_op <= lres_pkg::PAINT_SAD;
            default:              paint_op <= lres_pkg::PAINT_NEUTRAL;
          endcase
        end

        S_T_INC: begin
          now_ms <= alu_diff;
          state  <= S_T_GATE;
        end

        S_T_GATE: begin
          if (alu_diff < lres_pkg::GATE_MS) begin
            state <= S_IDLE;
          end else begin
            last_process_ms <= now_ms;
            state           <= running ? S_T_TMO : S_IDLE;
          end
        end

        S_T_TMO: begin
          if (end_time_ms != 32'd0 && !alu_borrow) begin
            // timeout: back to neutral
            running     <= 1'b0;
            end_time_ms <= '0;
            cur_expr    <= lres_pkg::EXPR_NEUTRAL;
            paint_op    <= lres_pkg::PAINT_NEUTRAL;
            idx         <= '0;
            state       <= S_PIX_RD;
          end else if (cur_expr == lres_pkg::EXPR_BLINK ||
                       cur_expr == lres_pkg::EXPR_ALERT) begin
            state <= S_T_BLK;
          end else begin
            state <= S_IDLE;
          end
        end

        S_T_BLK: begin
          if (alu_diff < lres_pkg::HALF_PERIOD_MS) begin
            state <= S_IDLE;
          end else begin
            last_blink_ms <= now_ms;
            blink_on      <= blink_next;
            idx           <= '0;
            state         <= S_PIX_RD;
            if (cur_expr == lres_pkg::EXPR_BLINK) begin
              paint_op  <= lres_pkg::PAINT_PILOT;
              paint_rgb <= '{r: 8'd0, g: blink_next ? half_level : 8'd0, b: 8'd0};
            end else begin
              alert_on_count <= alert_cnt_next;
              if (alert_second_stage) begin
                // second stage: only the alert pixel blinks
                paint_op  <= blink_next ? lres_pkg::PAINT_ALERT_PIX0
                                        : lres_pkg::PAINT_PIX0_OFF;
                paint_rgb <= '{r: alert_red, g: 8'd0, b: 8'd0};
              end else if (alert_cnt_next >= lres_pkg::ALERT_ON_MAX) begin
                // first stage over: continue if urgency holds, else neutral
                if (item_urgency) begin
                  alert_second_stage <= 1'b1;
                  alert_on_count     <= '0;
                  paint_op           <= lres_pkg::PAINT_FILL;
                  paint_rgb          <= '0;
                end else begin
                  running  <= 1'b0;
                  cur_expr <= lres_pkg::EXPR_NEUTRAL;
                  paint_op <= lres_pkg::PAINT_NEUTRAL;
                end
              end else begin
                paint_op  <= lres_pkg::PAINT_FILL;
                paint_rgb <= '{r: blink_next ? alert_red : 8'd0, g: 8'd0, b: 8'd0};
              end
            end
          end
        end

        S_PIX_RD: begin
          state <= S_PIX_WR;
        end

        S_PIX_WR: begin
          out_valid   <= 1'b1;
          out_index   <= 4'(idx);
          out_rgb     <= painted;
          out_forced  <= intensity_forced;
          out_expr    <= cur_expr;
          out_running <= running;
          out_last    <= pix_last;
          state       <= S_PIX_WAIT;
        end

        S_PIX_WAIT: begin
          if (pix.ready) begin
            out_valid <= 1'b0;
            if (pix_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_PIX_WR;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign pix.valid           = out_valid;
  assign pix.pixel_index     = out_index;
  assign pix.red             = out_rgb.r;
  assign pix.green           = out_rgb.g;
  assign pix.blue            = out_rgb.b;
  assign pix.full_intensity  = out_forced;
  assign pix.expression_code = out_expr;
  assign pix.effect_running  = out_running;
  assign pix.frame_last      = out_last;

endmodule

[tb/led_ring_expression_sequencer_test.sv]
// Self-checking testbench for the LED ring expression sequencer: a directed table, then
// random command/tick episodes over several brightness and alert-level settings.
// Depends on lres_pkg, lres_if and the led_ring_expression_sequencer RTL.
module led_ring_expression_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING         = 12;
  localparam int GATE         = 30;    // ms between processed ticks
  localparam int HALF_PERIOD  = 1000;  // ms per blink/alert toggle
  localparam int FLASHES      = 3;     // full-ring alert flashes before the decision
  localparam int PILOT        = 6;
  localparam int ITEMS        = 380;   // random commands plus ticks that redraw
  localparam int PHASES       = 5;
  localparam int DRAIN_CYCLES = 12;    // lets a silent tick finish inside the block
  localparam int TICK_BUDGET  = 70000; // random ticks before bursts are kept short
  localparam int LIMIT_NS     = 400000000;

  localparam logic TICK    = 1'b0;
  localparam logic COMMAND = 1'b1;
  localparam lres_pkg::rgb_t DARK = 24'h000000;

  // One pixel beat as it leaves the block.
  typedef struct packed {
    logic [3:0]      idx;
    lres_pkg::rgb_t  color;
    logic            fi;
    lres_pkg::expr_t code;
    logic            run;
    logic            last;
  } pixel_beat_t;

  // How a directed row is checked: by the predictor, as drawing nothing, or by a typed frame.
  typedef enum logic [1:0] {BY_MODEL, NO_FRAME, TYPED_FRAME} row_check_t;

  typedef struct packed {
    logic            mode;
    logic [2:0]      expr;
    logic [31:0]     timeout;
    logic            urgency;
    logic            cancel_clock;  // timeout = -now, so the deadline wraps to zero
    logic [15:0]     reps;
    row_check_t      check;
    logic [11:0]     mask;          // typed frame: pixels lit with 'lit', rest dark
    lres_pkg::rgb_t  lit;
    lres_pkg::expr_t code;
    logic            run;
    logic            fi;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [lres_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lres_pkg::CFG_DATA_W-1:0]  cfg_data;

  lres_cmd_if cmd();
  lres_pix_if pix();

  led_ring_expression_sequencer #(.NUM_PIXELS(RING)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .pix       (pix)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Ring predictor: own copy of timers, effect state, registers and frame.
  // ---------------------------------------------------------------------------
  logic [7:0]      level;          // brightness register
  logic [7:0]      alert_level;    // alert red register, 0 reads as full red
  logic [31:0]     now_ms;
  logic [31:0]     last_gate_ms;
  logic [31:0]     last_toggle_ms;
  logic [31:0]     deadline_ms;    // 0 = persistent
  logic            active;
  lres_pkg::expr_t shown;
  logic            lit_phase;
  logic [1:0]      flashes;        // saturates at 3
  logic            pix0_stage;     // alert second stage: only pixel 0 blinks
  logic            forced;         // sticky once white has been applied
  lres_pkg::rgb_t  ring [RING];

  pixel_beat_t pixel_q [$];    // expected pixel beats, oldest first
  row_t        plan [$];

  int  mismatches;
  int  effective_items;        // commands and ticks that redraw
  bit  calm;                   // stretch with no idling on either side

  function automatic void fill(lres_pkg::rgb_t c);
    for (int i = 0; i < RING; i++) ring[i] = c;
  endfunction

  function automatic void draw_neutral();
    fill(DARK);
    for (int i = 5; i <= 7; i++) ring[i] = {8'd0, level >> 1, 8'd0};
  endfunction

  // Expression command; returns 1 when the ring is redrawn.
  function automatic bit apply_cmd(logic [2:0] e, logic [31:0] t);
    logic [7:0] med;
    med = level >> 1;
    shown          = (e == lres_pkg::EXPR_NONE) ? lres_pkg::EXPR_UNKNOWN
                                                : lres_pkg::expr_t'(e);
    active         = 1'b1;
    last_toggle_ms = now_ms;
    lit_phase      = 1'b0;
    flashes        = 2'd0;
    pix0_stage     = 1'b0;
    deadline_ms    = (t == 32'd0) ? 32'd0 : now_ms + t;
    case (shown)
      lres_pkg::EXPR_BLINK: ring[PILOT] = DARK;
      lres_pkg::EXPR_WHITE: begin
        forced = 1'b1;
        fill(24'hFFFFFF);
      end
      lres_pkg::EXPR_ALERT: return 1'b0;
      lres_pkg::EXPR_SMILE: begin
        fill(DARK);
        for (int i = 4; i <= 8; i++) ring[i] = {8'd0, med, 8'd0};
      end
      lres_pkg::EXPR_SAD: begin
        fill(DARK);
        // frown wraps across pixel 0
        ring[10] = {med, med >> 1, 8'd0};
        ring[11] = {med, med >> 1, 8'd0};
        for (int i = 0; i <= 2; i++) ring[i] = {med, med >> 1, 8'd0};
      end
      default: draw_neutral();
    endcase
    return 1'b1;
  endfunction

  // One millisecond tick; returns 1 when the ring is redrawn.
  function automatic bit advance_ms(logic u);
    logic [31:0] since;
    logic [7:0]  red;
    red    = (alert_level != 8'd0) ? alert_level : 8'd255;
    now_ms = now_ms + 32'd1;
    since  = now_ms - last_gate_ms;
    if (since < GATE) return 1'b0;
    last_gate_ms = now_ms;
    if (!active) return 1'b0;
    if (deadline_ms != 32'd0 && now_ms >= deadline_ms) begin
      active      = 1'b0;
      deadline_ms = 32'd0;
      shown       = lres_pkg::EXPR_NEUTRAL;
      draw_neutral();
      return 1'b1;
    end
    if (shown != lres_pkg::EXPR_BLINK && shown != lres_pkg::EXPR_ALERT) return 1'b0;
    since = now_ms - last_toggle_ms;
    if (since < HALF_PERIOD) return 1'b0;
    last_toggle_ms = now_ms;
    lit_phase      = !lit_phase;
    if (shown == lres_pkg::EXPR_BLINK) begin
      ring[PILOT] = {8'd0, lit_phase ? (level >> 1) : 8'd0, 8'd0};
      return 1'b1;
    end
    if (lit_phase && flashes < FLASHES) flashes = flashes + 2'd1;
    if (!pix0_stage) begin
      fill(lit_phase ? {red, 8'd0, 8'd0} : DARK);
    end else if (lit_phase) begin
      fill(DARK);
      ring[0] = {red, 8'd0, 8'd0};
    end else begin
      ring[0] = DARK;
    end
    // after the third flash: keep pixel 0 blinking while urgent, else fall back
    if (!pix0_stage && flashes >= FLASHES) begin
      if (u) begin
        pix0_stage = 1'b1;
        flashes    = 2'd0;
        fill(DARK);
      end else begin
        active = 1'b0;
        shown  = lres_pkg::EXPR_NEUTRAL;
        draw_neutral();
      end
    end
    return 1'b1;
  endfunction

  function automatic void queue_frame();
    for (int k = 0; k < RING; k++)
      pixel_q.push_back({4'(k), ring[k], forced, shown, active, k == RING - 1});
  endfunction

  function automatic row_t row(logic m, logic [2:0] e, logic [31:0] t, logic u, logic cancel,
                               int reps, row_check_t chk, logic [11:0] mask,
                               lres_pkg::rgb_t lit, lres_pkg::expr_t code, logic run,
                               logic fi);
    return {m, e, t, u, cancel, 16'(reps), chk, mask, lit, code, run, fi};
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. valid is only lowered when a gap follows, so back-to-back
  // beats keep it high; the beat is predicted at the edge it is accepted.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic m, input logic [2:0] e, input logic [31:0] t,
                           input logic u, output bit drawn);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid          <= 1'b1;
    cmd.mode           <= m;
    cmd.expression     <= e;
    cmd.timeout_ms     <= t;
    cmd.urgency_active <= u;
    do @(posedge clk); while (!cmd.ready);
    drawn = m ? apply_cmd(e, t) : advance_ms(u);
    if (m || drawn) effective_items++;
  endtask

  // Hold the sender until every queued pixel beat has come, then let the
  // block finish any silent tick it may still be working on.
  task automatic drain_results();
    cmd.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random episodes: a command with random content, then a burst of ticks long
  // enough, now and then, to carry blink and alert patterns through.
  task automatic random_phase(input int goal, inout int budget);
    int          start;
    int          n;
    int          policy;
    logic [2:0]  e;
    logic [31:0] t;
    logic        u;
    bit          drawn;
    start = effective_items;
    while (effective_items - start < goal) begin
      calm = ($urandom_range(0, 3) == 0);
      e = ($urandom_range(0, 5) == 0) ? lres_pkg::EXPR_ALERT : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1, 2: t = 32'd0;
        3, 4, 5: t = $urandom_range(1, 120);
        6, 7:    t = $urandom_range(120, 4000);
        8:       t = $urandom;
        // deadline lands near zero: wraps to persistent, or expires at once
        default: t = 32'd0 - now_ms + $urandom_range(0, 80) - 32'd40;
      endcase
      send_beat(COMMAND, e, t, 1'($urandom_range(0, 1)), drawn);
      if (drawn) queue_frame();

      if (e == lres_pkg::EXPR_ALERT && budget > 0 && $urandom_range(0, 9) < 4) begin
        n = $urandom_range(5000, 7500);  // through all flashes and into the second stage
        calm = ($urandom_range(0, 3) != 0);
      end else begin
        case ($urandom_range(0, 19)) inside
          [0:10]:  n = $urandom_range(0, 40);
          [11:16]: n = $urandom_range(30, 300);
          default: n = (budget > 0) ? $urandom_range(1000, 2600) : $urandom_range(0, 40);
        endcase
      end
      budget -= n;
      policy = $urandom_range(0, 2);
      for (int k = 0; k < n; k++) begin
        u = (policy == 2) ? 1'($urandom_range(0, 1)) : (policy == 1);
        // ticks carry junk in the fields the block ignores for them
        send_beat(TICK, 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 7) == 0) ? $urandom : 32'd0, u, drawn);
        if (drawn) queue_frame();
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel side: random stall per beat, each beat checked against the oldest
  // expectation field by field.
  // ---------------------------------------------------------------------------
  initial begin
    int          stall;
    pixel_beat_t got;
    pixel_beat_t want;
    pix.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        pix.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix.ready <= 1'b1;
      do @(posedge clk); while (!pix.valid);
      got = {pix.pixel_index, pix.red, pix.green, pix.blue, pix.full_intensity,
             lres_pkg::expr_t'(pix.expression_code), pix.effect_running, pix.frame_last};
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel beat: idx %0d rgb %h fi %0d code %0d run %0d last %0d",
                   got.idx, got.color, got.fi, got.code, got.run, got.last);
      end else begin
        want = pixel_q.pop_front();
        if (got.idx !== want.idx || got.color !== want.color || got.fi !== want.fi ||
            got.code !== want.code || got.run !== want.run || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel beat mismatch at %0t ns", $realtime);
            $display("  expected idx %0d rgb %h fi %0d code %0d run %0d last %0d",
                     want.idx, want.color, want.fi, want.code, want.run, want.last);
            $display("  actual   idx %0d rgb %h fi %0d code %0d run %0d last %0d",
                     got.idx, got.color, got.fi, got.code, got.run, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    row_t        r;
    bit          drawn;
    logic [31:0] t;
    logic [7:0]  b;
    logic [7:0]  a;
    int          budget;

    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_index          <= lres_pkg::CFG_BRIGHTNESS;
    cfg_data           <= '0;
    cmd.valid          <= 1'b0;
    cmd.mode           <= TICK;
    cmd.expression     <= lres_pkg::EXPR_NONE;
    cmd.timeout_ms     <= '0;
    cmd.urgency_active <= 1'b0;

    level          = 8'd128;
    alert_level    = 8'd0;
    now_ms         = '0;
    last_gate_ms   = '0;
    last_toggle_ms = '0;
    deadline_ms    = '0;
    active         = 1'b0;
    shown          = lres_pkg::EXPR_NONE;
    lit_phase      = 1'b0;
    flashes        = 2'd0;
    pix0_stage     = 1'b0;
    forced         = 1'b0;
    fill(DARK);
    mismatches      = 0;
    effective_items = 0;
    calm            = 1'b0;
    budget          = TICK_BUDGET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset register values (half level 0x40). Typed frames
    // are the ones readable at a glance; the rest go through the predictor.
    //                 mode     expr                    timeout        u  cancel reps check
    plan.push_back(row(TICK,    lres_pkg::EXPR_NONE,    32'd0,         0, 0, 1,    NO_FRAME,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));  // gated tick
    plan.push_back(row(COMMAND, lres_pkg::EXPR_NEUTRAL, 32'd0,         0, 0, 1,    TYPED_FRAME,
                       12'h0E0, 24'h004000, lres_pkg::EXPR_NEUTRAL, 1, 0));
    plan.push_back(row(COMMAND, lres_pkg::EXPR_UNKNOWN, 32'd0,         0, 0, 1,    TYPED_FRAME,
                       12'h0E0, 24'h004000, lres_pkg::EXPR_UNKNOWN, 1, 0));
    // code zero draws neutral and reads back as unknown
    plan.push_back(row(COMMAND, lres_pkg::EXPR_NONE,    32'd0,         0, 0, 1,    TYPED_FRAME,
                       12'h0E0, 24'h004000, lres_pkg::EXPR_UNKNOWN, 1, 0));
    plan.push_back(row(COMMAND, lres_pkg::EXPR_SMILE,   32'd0,         0, 0, 1,    TYPED_FRAME,
                       12'h1F0, 24'h004000, lres_pkg::EXPR_SMILE,   1, 0));
    plan.push_back(row(COMMAND, lres_pkg::EXPR_SAD,     32'd0,         0, 0, 1,    BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    // alert command draws nothing
    plan.push_back(row(COMMAND, lres_pkg::EXPR_ALERT,   32'd0,         0, 0, 1,    NO_FRAME,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(COMMAND, lres_pkg::EXPR_WHITE,   32'd0,         0, 0, 1,    TYPED_FRAME,
                       12'hFFF, 24'hFFFFFF, lres_pkg::EXPR_WHITE,   1, 1));
    plan.push_back(row(COMMAND, lres_pkg::EXPR_BLINK,   32'd0,         0, 0, 1,    BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    // 1 ms timeout, expires at the first open gate
    plan.push_back(row(COMMAND, lres_pkg::EXPR_SMILE,   32'd1,         0, 0, 1,    BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(TICK,    lres_pkg::EXPR_NONE,    32'd0,         0, 0, 40,   BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    // maximum timeout: deadline wraps just behind the clock, expires at once
    plan.push_back(row(COMMAND, lres_pkg::EXPR_ALERT,   32'hFFFFFFFF,  1, 0, 1,    NO_FRAME,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(TICK,    lres_pkg::EXPR_NONE,    32'd0,         1, 0, 30,   BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    // deadline wraps to exactly zero, so the blink is persistent
    plan.push_back(row(COMMAND, lres_pkg::EXPR_BLINK,   32'd0,         0, 1, 1,    BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(TICK,    lres_pkg::EXPR_NONE,    32'd0,         0, 0, 2050, BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    // urgent alert: three flashes, then pixel 0 keeps blinking
    plan.push_back(row(COMMAND, lres_pkg::EXPR_ALERT,   32'd0,         0, 0, 1,    NO_FRAME,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(TICK,    lres_pkg::EXPR_NONE,    32'd0,         1, 0, 7200, BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    // calm alert: three flashes, then back to neutral
    plan.push_back(row(COMMAND, lres_pkg::EXPR_ALERT,   32'd0,         1, 0, 1,    NO_FRAME,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(TICK,    lres_pkg::EXPR_NONE,    32'd0,         0, 0, 5100, BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(COMMAND, lres_pkg::EXPR_SAD,     32'h80000000,  1, 0, 1,    BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));
    plan.push_back(row(TICK,    lres_pkg::EXPR_NONE,    32'd0,         0, 0, 40,   BY_MODEL,
                       12'h000, DARK,       lres_pkg::EXPR_NONE,    0, 0));

    foreach (plan[i]) begin
      r = plan[i];
      calm = ($urandom_range(0, 2) == 0);
      repeat (r.reps) begin
        t = r.cancel_clock ? 32'd0 - now_ms : r.timeout;
        send_beat(r.mode, r.expr, t, r.urgency, drawn);
        case (r.check)
          BY_MODEL: if (drawn) queue_frame();
          TYPED_FRAME: begin
            for (int k = 0; k < RING; k++)
              pixel_q.push_back({4'(k), r.mask[k] ? r.lit : DARK, r.fi, r.code, r.run,
                                 k == RING - 1});
          end
          default: ;
        endcase
      end
    end

    // Random phases, each behind a register update done while the block is idle.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin b = 8'd255; a = 8'd0;   end
        1: begin b = 8'd0;   a = 8'd255; end
        2: begin b = 8'd1;   a = 8'd1;   end
        default: begin
          b = 8'($urandom);
          a = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        end
      endcase
      cfg_write <= 1'b1;
      cfg_index <= lres_pkg::CFG_BRIGHTNESS;
      cfg_data  <= b;
      @(posedge clk);
      level = b;
      cfg_index <= lres_pkg::CFG_ALERT_RED;
      cfg_data  <= a;
      @(posedge clk);
      alert_level = a;
      cfg_write <= 1'b0;
      random_phase(ITEMS / PHASES, budget);
    end

    drain_results();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard: several times the slowest legal run.
  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

[led_ring_expression_sequencer.f]
rtl/lres_pkg.sv
rtl/lres_if.sv
rtl/lres_alu.sv
rtl/lres_fb.sv
rtl/lres_paint.sv
rtl/led_ring_expression_sequencer.sv
tb/led_ring_expression_sequencer_test.sv
